@@ hdl/htpt_pkg.sv @@
// Shared types, constants and tag-name matching for the HTML-to-text filter.
package htpt_pkg;

  // Tag name buffer
  localparam int TAG_NAME_MAX = 8;
  localparam int TAG_LEN_W    = $clog2(TAG_NAME_MAX + 1);
  localparam int TAG_IDX_W    = $clog2(TAG_NAME_MAX);

  // Longest name in the match lists ("/footer")
  localparam int NAME_LIT_LEN = 7;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef logic [TAG_NAME_MAX-1:0][7:0] tag_store_t;
  typedef logic [TAG_LEN_W-1:0]         tag_len_t;

  // What was emitted last
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  // Tag classes that add newlines on '>'
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_HEAD,
    CLS_PARA,
    CLS_BLOCK,
    CLS_BR
  } tag_class_t;

  // One result character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } entry_t;

  // Results produced by one request, pushed to the queue together
  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  // Compare the stored name with a literal of n characters (first char at the top)
  function automatic logic name_eq(input tag_store_t st, input tag_len_t len,
                                   input logic [8*NAME_LIT_LEN-1:0] lit,
                                   input int unsigned n);
    logic eq;
    eq = (len == TAG_LEN_W'(n));
    for (int unsigned k = 0; k < NAME_LIT_LEN; k++) begin
      if (k < n) begin
        if (st[k] != lit[8*(n-1-k) +: 8]) begin
          eq = 1'b0;
        end
      end
    end
    return eq;
  endfunction

  // Sort the captured name into its newline class
  function automatic tag_class_t classify(input tag_store_t st, input tag_len_t len,
                                          input logic ovf);
    tag_class_t cls;
    cls = CLS_NONE;
    if (!ovf) begin
      if (name_eq(st, len, "h1", 2) || name_eq(st, len, "/h1", 3) ||
          name_eq(st, len, "h2", 2) || name_eq(st, len, "/h2", 3) ||
          name_eq(st, len, "h3", 2) || name_eq(st, len, "/h3", 3) ||
          name_eq(st, len, "h4", 2) || name_eq(st, len, "/h4", 3) ||
          name_eq(st, len, "h5", 2) || name_eq(st, len, "/h5", 3) ||
          name_eq(st, len, "h6", 2) || name_eq(st, len, "/h6", 3)) begin
        cls = CLS_HEAD;
      end else if (name_eq(st, len, "p", 1) || name_eq(st, len, "/p", 2)) begin
        cls = CLS_PARA;
      end else if (name_eq(st, len, "div", 3) || name_eq(st, len, "/div", 4) ||
                   name_eq(st, len, "ol", 2) || name_eq(st, len, "/ol", 3) ||
                   name_eq(st, len, "ul", 2) || name_eq(st, len, "/ul", 3) ||
                   name_eq(st, len, "li", 2) || name_eq(st, len, "/li", 3) ||
                   name_eq(st, len, "dl", 2) || name_eq(st, len, "/dl", 3) ||
                   name_eq(st, len, "dt", 2) || name_eq(st, len, "/dt", 3) ||
                   name_eq(st, len, "dd", 2) || name_eq(st, len, "/dd", 3) ||
                   name_eq(st, len, "footer", 6) ||
                   name_eq(st, len, "/footer", 7)) begin
        cls = CLS_BLOCK;
      end else if (name_eq(st, len, "br", 2)) begin
        cls = CLS_BR;
      end
    end
    return cls;
  endfunction

endpackage

@@ hdl/htpt_in_if.sv @@
// Input channel: HTML bytes with end-of-document flag.
interface htpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_document;

  modport source (output valid, output in_byte, output end_of_document, input ready);
  modport sink   (input valid, input in_byte, input end_of_document, output ready);
endinterface

@@ hdl/htpt_out_if.sv @@
// Output channel: plain text characters.
interface htpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ hdl/htpt_filter_core.sv @@
// Input register, tag parser state and result generation for one byte per cycle while the result queue has room.
module htpt_filter_core (
  input  logic            clk,
  input  logic            rst,
  htpt_in_if.sink         in_stream,
  input  logic            room,
  output htpt_pkg::push_t push
);

  // Input register
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_eod;
  logic       fire;

  // Parser state
  logic                 inside_tag, inside_tag_next;
  htpt_pkg::tag_store_t tag_store;
  htpt_pkg::tag_len_t   tag_len, tag_len_next;
  logic                 word_done, word_done_next;
  logic                 name_ovf, name_ovf_next;
  htpt_pkg::kind_t      kind, kind_next;
  logic                 store_we;
  htpt_pkg::tag_class_t cls;
  logic                 is_sep;

  assign fire            = q_valid && room;
  assign in_stream.ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      q_byte <= in_stream.in_byte;
      q_eod  <= in_stream.end_of_document;
    end
  end

  assign cls    = htpt_pkg::classify(tag_store, tag_len, name_ovf);
  assign is_sep = (q_byte == htpt_pkg::CH_SP) || (q_byte == htpt_pkg::CH_NL);

  // Next state and results for the registered byte
  always_comb begin
    inside_tag_next = inside_tag;
    tag_len_next    = tag_len;
    word_done_next  = word_done;
    name_ovf_next   = name_ovf;
    kind_next       = kind;
    store_we        = 1'b0;
    push.cnt        = 2'd0;
    push.e0         = '{ch: htpt_pkg::CH_NL, last: 1'b1};
    push.e1         = '{ch: htpt_pkg::CH_NL, last: 1'b1};

    if (inside_tag) begin
      if (q_byte == htpt_pkg::CH_GT) begin
        inside_tag_next = 1'b0;
        if (kind != htpt_pkg::KIND_NONE) begin
          unique case (cls)
            htpt_pkg::CLS_HEAD: begin
              // end in a blank line
              if (kind != htpt_pkg::KIND_NEWLINE) begin
                push.cnt     = 2'd2;
                push.e0.last = 1'b0;
              end else begin
                push.cnt = 2'd1;
              end
              kind_next = htpt_pkg::KIND_NEWLINE;
            end
            htpt_pkg::CLS_PARA, htpt_pkg::CLS_BR: begin
              push.cnt  = 2'd1;
              kind_next = htpt_pkg::KIND_NEWLINE;
            end
            htpt_pkg::CLS_BLOCK: begin
              if (kind != htpt_pkg::KIND_NEWLINE) begin
                push.cnt  = 2'd1;
                kind_next = htpt_pkg::KIND_NEWLINE;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (is_sep) begin
        if ((tag_len != '0) || name_ovf) begin
          word_done_next = 1'b1;
        end
      end else if (!word_done) begin
        if (tag_len < htpt_pkg::TAG_LEN_W'(htpt_pkg::TAG_NAME_MAX)) begin
          store_we     = 1'b1;
          tag_len_next = tag_len + htpt_pkg::TAG_LEN_W'(1);
        end else begin
          name_ovf_next = 1'b1;
        end
      end
    end else begin
      if (q_byte == htpt_pkg::CH_LT) begin
        inside_tag_next = 1'b1;
        tag_len_next    = '0;
        word_done_next  = 1'b0;
        name_ovf_next   = 1'b0;
      end else if (is_sep) begin
        // collapse whitespace runs to one space
        if (kind == htpt_pkg::KIND_OTHER) begin
          push.cnt   = 2'd1;
          push.e0.ch = htpt_pkg::CH_SP;
          kind_next  = htpt_pkg::KIND_SPACE;
        end
      end else begin
        push.cnt   = 2'd1;
        push.e0.ch = q_byte;
        kind_next  = htpt_pkg::KIND_OTHER;
      end
    end

    // end of document returns control state to reset
    if (q_eod) begin
      inside_tag_next = 1'b0;
      tag_len_next    = '0;
      word_done_next  = 1'b0;
      name_ovf_next   = 1'b0;
      kind_next       = htpt_pkg::KIND_NONE;
    end

    if (!fire) begin
      push.cnt = 2'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag <= 1'b0;
      tag_len    <= '0;
      word_done  <= 1'b0;
      name_ovf   <= 1'b0;
      kind       <= htpt_pkg::KIND_NONE;
    end else if (fire) begin
      inside_tag <= inside_tag_next;
      tag_len    <= tag_len_next;
      word_done  <= word_done_next;
      name_ovf   <= name_ovf_next;
      kind       <= kind_next;
    end
  end

  // Name buffer, no reset
  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      tag_store[tag_len[htpt_pkg::TAG_IDX_W-1:0]] <= q_byte;
    end
  end

`ifndef SYNTHESIS
  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    fire && q_eod |=> !inside_tag && (tag_len == '0) && (kind == htpt_pkg::KIND_NONE))
    else $error("state not cleared after end of document");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    name_ovf |-> (tag_len == htpt_pkg::TAG_LEN_W'(htpt_pkg::TAG_NAME_MAX)))
    else $error("overflow flagged with name buffer not full");

  a_emit_kind: assert property (@(posedge clk) disable iff (rst)
    fire && (push.cnt != 2'd0) && !q_eod |=> (kind != htpt_pkg::KIND_NONE))
    else $error("output emitted but last kind still none");
`endif

endmodule

@@ hdl/htpt_result_fifo.sv @@
// Result queue: takes up to two characters per request, hands out one per cycle while the output is ready.
module htpt_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  htpt_pkg::push_t push,
  output logic            room,
  htpt_out_if.source      out_stream
);

  htpt_pkg::entry_t              mem [htpt_pkg::FIFO_DEPTH];
  logic [htpt_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [htpt_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [htpt_pkg::FIFO_CNT_W-1:0] count;
  logic [htpt_pkg::FIFO_CNT_W-1:0] count_next;
  logic                          pop;

  assign room = (count <= htpt_pkg::FIFO_CNT_W'(htpt_pkg::FIFO_DEPTH - 2));
  assign pop  = out_stream.valid && out_stream.ready;

  assign out_stream.valid       = (count != '0);
  assign out_stream.out_char    = mem[rd_ptr].ch;
  assign out_stream.last_of_run = mem[rd_ptr].last;

  // Occupancy after this cycle's push and pop
  always_comb begin
    count_next = count + htpt_pkg::FIFO_CNT_W'(push.cnt);
    if (pop) begin
      count_next = count_next - htpt_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + htpt_pkg::FIFO_PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + htpt_pkg::FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + htpt_pkg::FIFO_PTR_W'(1)] <= push.e1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= htpt_pkg::FIFO_CNT_W'(htpt_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("push without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd0) && pop |=> count == $past(count) - htpt_pkg::FIFO_CNT_W'(1))
    else $error("pop did not reduce occupancy");
`endif

endmodule

@@ hdl/html_to_plain_text_filter.sv @@
// Each accepted byte is registered; its results then go into the result queue.
// Throughput: one byte per cycle while the queue has room; the output port moves one
// character per cycle while ready, and a heading close can yield two newlines.
// A four-entry result queue lets input continue while a result waits to be taken.
// Reset (rst, synchronous) clears parser state and the queue; the name buffer
// is not reset.
module html_to_plain_text_filter (
  input  logic       clk,
  input  logic       rst,
  htpt_in_if.sink    in_stream,
  htpt_out_if.source out_stream
);

  htpt_pkg::push_t push;
  logic            room;

  htpt_filter_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .room      (room),
    .push      (push)
  );

  htpt_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_stream (out_stream)
  );

endmodule
